// File: hdl/heightmap_bilinear_sampler_assert.svh
// Assertion macros shared by the height-map sampler RTL.
// Needs nothing but the clock and reset names given as arguments.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbs: same-cycle implication violated");

// Consequent must hold in the cycle after the antecedent.
`define HBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbs: next-cycle implication violated");

`endif

// File: hdl/hbs_pkg.sv
// Package of the height-map bilinear sampler: field widths, codes, defaults,
// the control struct of the shared multiply-accumulate unit and gray helper.
`timescale 1ns / 1ps

package hbs_pkg;

   // Fixed field widths.
   localparam int PIX_W     = 8;
   localparam int Q_W       = 16;
   localparam int CFG_DIM_W = 9;
   localparam int GAIN_W    = 16;
   localparam int HGT_W     = 24;
   localparam int SUM_W     = 10;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLACK_IS_HIGH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_GAIN   = 2'd3;

   localparam logic [CFG_DIM_W-1:0] RST_GRID_WIDTH  = 9'd256;
   localparam logic [CFG_DIM_W-1:0] RST_GRID_HEIGHT = 9'd256;
   localparam logic [GAIN_W-1:0]    RST_HEIGHT_GAIN = 16'd256;

   // Item function codes.
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [PIX_W-1:0] GRAY_MAX = 8'd255;

   // Parameter defaults.
   localparam int DEF_MAX_WIDTH       = 256;
   localparam int DEF_MAX_HEIGHT      = 256;
   localparam int DEF_COORD_FRAC_BITS = 8;

   // Division by three as multiplication by 683/2048; exact for sums up to 765.
   localparam int DIV3_RECIP = 683;
   localparam int DIV3_SHIFT = 11;
   localparam int DIV3_PW    = SUM_W + DIV3_SHIFT;

   typedef struct packed {
      logic en;
      logic clear;
   } mac_ctrl_type;

   function automatic logic [PIX_W-1:0] gray_of_sum(input logic [SUM_W-1:0] s);
      logic [DIV3_PW-1:0] p;
      p = DIV3_PW'(s) * DIV3_PW'(DIV3_RECIP);
      return p[DIV3_SHIFT +: PIX_W];
   endfunction

endpackage

// File: hdl/hbs_channels.sv
// Valid/ready channel interfaces of the height-map sampler: request and response.
// Depends on hbs_pkg for the field widths.
`timescale 1ns / 1ps

interface hbs_req_if;
   import hbs_pkg::*;
   logic             valid;
   logic             ready;
   logic             func;
   logic [PIX_W-1:0] pixel_col;
   logic [PIX_W-1:0] pixel_row;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   logic [Q_W-1:0]   query_x;
   logic [Q_W-1:0]   query_y;

   modport source (output valid, func, pixel_col, pixel_row, red, green, blue,
                   query_x, query_y, input ready);
   modport sink (input valid, func, pixel_col, pixel_row, red, green, blue,
                 query_x, query_y, output ready);
endinterface

interface hbs_rsp_if;
   import hbs_pkg::*;
   logic             valid;
   logic             ready;
   logic [HGT_W-1:0] height;
   logic             inside_res;
   logic [HGT_W-1:0] max_height;
   logic [HGT_W-1:0] min_height;

   modport source (output valid, height, inside_res, max_height, min_height,
                   input ready);
   modport sink (input valid, height, inside_res, max_height, min_height,
                 output ready);
endinterface

// File: hdl/hbs_grid_ram.sv
// Height grid memory: one write port and one read port with registered data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module hbs_grid_ram #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16,
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/hbs_mac.sv
// Shared multiply-accumulate unit of the sampler, one product per cycle
// while ctrl.en is set, added to or loaded into acc. Depends on hbs_pkg.
`timescale 1ns / 1ps

module hbs_mac #(
   parameter int A_W   = 32,
   parameter int B_W   = 16,
   parameter int ACC_W = 48
) (
   input  logic                 clock,
   input  hbs_pkg::mac_ctrl_type ctrl,
   input  logic [A_W-1:0]       op_a,
   input  logic [B_W-1:0]       op_b,
   output logic [ACC_W-1:0]     acc
);
   import hbs_pkg::*;

   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;
   logic [ACC_W-1:0] product;

   always_comb begin
      product = ACC_W'(op_a) * ACC_W'(op_b);
      acc_in  = (ctrl.clear ? '0 : acc_ff) + product;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// File: hdl/heightmap_bilinear_sampler.sv
// Height-map bilinear sampler. A load word turns one RGB pixel into a height
// (channel mean, optional inversion, times the Q8.8 gain) and writes it to the
// grid memory while tracking the running maximum and minimum; a query word
// returns the bilinear height at a fixed-point coordinate plus max and min.
// The block takes one word at a time. A load inside the grid passes the gray,
// multiply and write states, a load outside only the gray state. A query
// inside the grid passes the check state, four neighbor reads through the
// single grid read port and six passes through the one shared
// multiply-accumulate unit; a query outside goes from check to done. Queries
// also wait for any response word still held by rsp_chan; loads do not.
`timescale 1ns / 1ps
`include "heightmap_bilinear_sampler_assert.svh"

module heightmap_bilinear_sampler #(
   parameter int MAX_WIDTH       = hbs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT      = hbs_pkg::DEF_MAX_HEIGHT,
   parameter int COORD_FRAC_BITS = hbs_pkg::DEF_COORD_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   hbs_req_if.sink                        req_chan,
   hbs_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [hbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hbs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hbs_pkg::*;

   localparam int FRAC   = COORD_FRAC_BITS;
   localparam int IX_W   = Q_W - FRAC;
   localparam int DIM_W  = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
   localparam int CW0    = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
   localparam int CMP_W  = (CW0 > IX_W + 1) ? CW0 : IX_W + 1;
   localparam int AW2    = 2 * CMP_W;
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int A_W    = HGT_W + FRAC;
   localparam int B_W    = (FRAC + 1 > GAIN_W) ? FRAC + 1 : GAIN_W;
   localparam int ACC_W  = A_W + B_W;

   localparam logic [FRAC:0]      S_ONE   = {1'b1, {FRAC{1'b0}}};
   localparam logic [CMP_W-1:0]   MAX_W_C = CMP_W'(MAX_WIDTH);
   localparam logic [CMP_W-1:0]   MAX_H_C = CMP_W'(MAX_HEIGHT);
   localparam logic [CMP_W-1:0]   ONE_C   = CMP_W'(1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_L_GRAY,
      S_L_MUL,
      S_L_WR,
      S_Q_CHK,
      S_Q_RD00,
      S_Q_RD10,
      S_Q_RD01,
      S_Q_RD11,
      S_Q_M11,
      S_Q_VY0,
      S_Q_VY1,
      S_Q_DONE
   } state_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [CMP_W-1:0] col,
                                                  input logic [CMP_W-1:0] row);
      logic [AW2-1:0] t;
      t = AW2'(row) * AW2'(MAX_WIDTH) + AW2'(col);
      return t[ADDR_W-1:0];
   endfunction

   // Configuration registers.
   logic [CFG_DIM_W-1:0] cfg_width_ff;
   logic [CFG_DIM_W-1:0] cfg_height_ff;
   logic                 cfg_black_ff;
   logic [GAIN_W-1:0]    cfg_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= RST_GRID_WIDTH;
         cfg_height_ff <= RST_GRID_HEIGHT;
         cfg_black_ff  <= 1'b0;
         cfg_gain_ff   <= RST_HEIGHT_GAIN;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_WIDTH:    cfg_width_ff  <= csr_wdata[CFG_DIM_W-1:0];
            CSR_GRID_HEIGHT:   cfg_height_ff <= csr_wdata[CFG_DIM_W-1:0];
            CSR_BLACK_IS_HIGH: cfg_black_ff  <= csr_wdata[0];
            CSR_HEIGHT_GAIN:   cfg_gain_ff   <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective grid size, clamped to 1..MAX.
   logic [CMP_W-1:0] w_eff;
   logic [CMP_W-1:0] h_eff;

   always_comb begin
      w_eff = CMP_W'(cfg_width_ff);
      if (w_eff == '0) begin
         w_eff = ONE_C;
      end else if (w_eff > MAX_W_C) begin
         w_eff = MAX_W_C;
      end
      h_eff = CMP_W'(cfg_height_ff);
      if (h_eff == '0) begin
         h_eff = ONE_C;
      end else if (h_eff > MAX_H_C) begin
         h_eff = MAX_H_C;
      end
   end

   // Sequencer registers.
   state_type          state_ff, state_in;
   logic [PIX_W-1:0]   ld_col_ff, ld_col_in;
   logic [PIX_W-1:0]   ld_row_ff, ld_row_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [PIX_W-1:0]   gray_ff, gray_in;
   logic [Q_W-1:0]     qx_ff, qx_in;
   logic [Q_W-1:0]     qy_ff, qy_in;
   logic [CMP_W-1:0]   col0_ff, col0_in, col1_ff, col1_in;
   logic [CMP_W-1:0]   row0_ff, row0_in, row1_ff, row1_in;
   logic               inside_ff, inside_in;
   logic [A_W-1:0]     hold_ff, hold_in;
   logic [HGT_W-1:0]   run_max_ff, run_max_in;
   logic [HGT_W-1:0]   run_min_ff, run_min_in;
   logic               seen_first_ff, seen_first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [HGT_W-1:0]   rsp_height_ff, rsp_height_in;
   logic               rsp_inside_ff, rsp_inside_in;
   logic [HGT_W-1:0]   rsp_max_ff, rsp_max_in;
   logic [HGT_W-1:0]   rsp_min_ff, rsp_min_in;

   // Datapath controls.
   mac_ctrl_type       mac_ctrl;
   logic [A_W-1:0]     mac_a;
   logic [B_W-1:0]     mac_b;
   logic [ACC_W-1:0]   mac_acc;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [HGT_W-1:0]   mem_rdata;
   logic               rsp_load;

   logic               req_take;
   logic [FRAC-1:0]    fx, fy;
   logic [FRAC:0]      wfx, wfy;
   logic [CMP_W-1:0]   ix_ext, iy_ext;
   logic [CMP_W-1:0]   ld_col_ext, ld_row_ext;
   logic [PIX_W-1:0]   gray_raw;
   logic [HGT_W-1:0]   load_val;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;

   assign fx         = qx_ff[FRAC-1:0];
   assign fy         = qy_ff[FRAC-1:0];
   assign wfx        = S_ONE - {1'b0, fx};
   assign wfy        = S_ONE - {1'b0, fy};
   assign ix_ext     = CMP_W'(qx_ff >> FRAC);
   assign iy_ext     = CMP_W'(qy_ff >> FRAC);
   assign ld_col_ext = CMP_W'(ld_col_ff);
   assign ld_row_ext = CMP_W'(ld_row_ff);
   assign gray_raw   = gray_of_sum(sum_ff);
   assign load_val   = mac_acc[HGT_W-1:0];

   always_comb begin
      state_in      = state_ff;
      ld_col_in     = ld_col_ff;
      ld_row_in     = ld_row_ff;
      sum_in        = sum_ff;
      gray_in       = gray_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      col0_in       = col0_ff;
      col1_in       = col1_ff;
      row0_in       = row0_ff;
      row1_in       = row1_ff;
      inside_in     = inside_ff;
      hold_in       = hold_ff;
      run_max_in    = run_max_ff;
      run_min_in    = run_min_ff;
      seen_first_in = seen_first_ff;
      rsp_height_in = rsp_height_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_load      = 1'b0;
      mac_ctrl      = '0;
      mac_a         = '0;
      mac_b         = '0;
      mem_we        = 1'b0;
      mem_waddr     = addr_of(ld_col_ext, ld_row_ext);
      mem_raddr     = addr_of(col0_ff, row0_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_chan.func == FUNC_LOAD) begin
                  ld_col_in = req_chan.pixel_col;
                  ld_row_in = req_chan.pixel_row;
                  sum_in    = SUM_W'(req_chan.red) + SUM_W'(req_chan.green)
                            + SUM_W'(req_chan.blue);
                  state_in  = S_L_GRAY;
               end else begin
                  qx_in    = req_chan.query_x;
                  qy_in    = req_chan.query_y;
                  state_in = S_Q_CHK;
               end
            end
         end
         S_L_GRAY: begin
            gray_in = cfg_black_ff ? (GRAY_MAX - gray_raw) : gray_raw;
            if ((ld_col_ext < w_eff) && (ld_row_ext < h_eff)) begin
               state_in = S_L_MUL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_L_MUL: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = 1'b1;
            mac_a          = A_W'(gray_ff);
            mac_b          = B_W'(cfg_gain_ff);
            state_in       = S_L_WR;
         end
         S_L_WR: begin
            mem_we = 1'b1;
            if (!seen_first_ff) begin
               run_max_in    = load_val;
               run_min_in    = load_val;
               seen_first_in = 1'b1;
            end else begin
               if (load_val > run_max_ff) begin
                  run_max_in = load_val;
               end
               if (load_val < run_min_ff) begin
                  run_min_in = load_val;
               end
            end
            state_in = S_IDLE;
         end
         S_Q_CHK: begin
            inside_in = (ix_ext < w_eff) && (iy_ext < h_eff);
            col0_in   = ix_ext;
            row0_in   = iy_ext;
            col1_in   = (ix_ext < w_eff - ONE_C) ? ix_ext + ONE_C : ix_ext;
            row1_in   = (iy_ext < h_eff - ONE_C) ? iy_ext + ONE_C : iy_ext;
            state_in  = inside_in ? S_Q_RD00 : S_Q_DONE;
         end
         S_Q_RD00: begin
            mem_raddr = addr_of(col0_ff, row0_ff);
            state_in  = S_Q_RD10;
         end
         S_Q_RD10: begin
            // Top row: acc = (S-fx)*p00 + fx*p10.
            mem_raddr      = addr_of(col1_ff, row0_ff);
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = 1'b1;
            mac_a          = A_W'(mem_rdata);
            mac_b          = B_W'(wfx);
            state_in       = S_Q_RD01;
         end
         S_Q_RD01: begin
            mem_raddr   = addr_of(col0_ff, row1_ff);
            mac_ctrl.en = 1'b1;
            mac_a       = A_W'(mem_rdata);
            mac_b       = B_W'(fx);
            state_in    = S_Q_RD11;
         end
         S_Q_RD11: begin
            // Park the top-row sum and start the bottom row.
            mem_raddr      = addr_of(col1_ff, row1_ff);
            hold_in        = mac_acc[A_W-1:0];
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = 1'b1;
            mac_a          = A_W'(mem_rdata);
            mac_b          = B_W'(wfx);
            state_in       = S_Q_M11;
         end
         S_Q_M11: begin
            mac_ctrl.en = 1'b1;
            mac_a       = A_W'(mem_rdata);
            mac_b       = B_W'(fx);
            state_in    = S_Q_VY0;
         end
         S_Q_VY0: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = 1'b1;
            mac_a          = mac_acc[A_W-1:0];
            mac_b          = B_W'(fy);
            state_in       = S_Q_VY1;
         end
         S_Q_VY1: begin
            mac_ctrl.en = 1'b1;
            mac_a       = hold_ff;
            mac_b       = B_W'(wfy);
            state_in    = S_Q_DONE;
         end
         S_Q_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load      = 1'b1;
               rsp_height_in = inside_ff ? mac_acc[2*FRAC +: HGT_W] : '0;
               rsp_inside_in = inside_ff;
               rsp_max_in    = run_max_ff;
               rsp_min_in    = run_min_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         run_max_ff    <= '0;
         run_min_ff    <= '0;
         seen_first_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_max_ff    <= run_max_in;
         run_min_ff    <= run_min_in;
         seen_first_ff <= seen_first_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ld_col_ff     <= ld_col_in;
      ld_row_ff     <= ld_row_in;
      sum_ff        <= sum_in;
      gray_ff       <= gray_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      col0_ff       <= col0_in;
      col1_ff       <= col1_in;
      row0_ff       <= row0_in;
      row1_ff       <= row1_in;
      inside_ff     <= inside_in;
      hold_ff       <= hold_in;
      rsp_height_ff <= rsp_height_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_min_ff    <= rsp_min_in;
   end

   hbs_mac #(
      .A_W   (A_W),
      .B_W   (B_W),
      .ACC_W (ACC_W)
   ) u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   hbs_grid_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (HGT_W)
   ) u_grid (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (load_val),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.height     = rsp_height_ff;
   assign rsp_chan.inside_res = rsp_inside_ff;
   assign rsp_chan.max_height = rsp_max_ff;
   assign rsp_chan.min_height = rsp_min_ff;

   `HBS_ASSERT_IMPL(a_minmax_zero, clock, reset, !seen_first_ff, (run_max_ff == '0) && (run_min_ff == '0))
   `HBS_ASSERT_IMPL(a_min_le_max, clock, reset, seen_first_ff, run_min_ff <= run_max_ff)
   `HBS_ASSERT_IMPL(a_write_in_grid, clock, reset, mem_we, (ld_col_ext < w_eff) && (ld_row_ext < h_eff))
   `HBS_ASSERT_NEXT(a_outside_zero, clock, reset, rsp_load && !inside_ff, rsp_valid_ff && (rsp_height_ff == '0))

endmodule
